/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion macros, sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/pmq_pkg.sv */
// ----------------------------------------------------------------------------
// pmq_pkg
// shared types and constants of the priority message queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH    = 16;
	localparam int MAX_LENGTH             = 8192;
	localparam int RESET_MAX_MESSAGES     = 10;
	localparam int RESET_MAX_MESSAGE_SIZE = 8192;

	localparam int HANDLE_W   = 32;
	localparam int LEN_W      = 14;
	localparam int PRIO_W     = 15;
	localparam int REQ_PRIO_W = 16;
	localparam int CNT_W      = 5;
	localparam int SIZE_W     = 17;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_RECV = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_SIZE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_BUF_SMALL = 3'd4,
		ST_BAD_PRIO  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_POP
	} state_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    len;
		logic [PRIO_W-1:0]   prio;
	} msg_t;

endpackage

/* rtl/priority_message_queue.sv */
// A rejected word is answered straight from idle; a receive reads the head and then pops it; a send
// moves each held lower-priority message one slot toward the tail, then writes the new message.
// One word at a time: start is taken only while idle; busy is high while a word is worked on and falls as done rises.
// Each insert step is one read and one compare-and-write on the message memory, never both in one cycle.
// Reset: arst_n clears the queue and loads max_messages = 10, max_message_size = 8192.
// The receiver cannot stall: each result is shown on done for exactly one cycle.
// ----------------------------------------------------------------------------
// priority_message_queue
// bounded message queue, highest priority first, first in first out on ties
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_message_queue
	import pmq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [HANDLE_W-1:0]   payload_handle,
	input  logic [LEN_W-1:0]      length,
	input  logic [REQ_PRIO_W-1:0] priority_req,
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [HANDLE_W-1:0]   out_handle,
	output logic [LEN_W-1:0]      out_length,
	output logic [PRIO_W-1:0]     out_priority,
	output logic [CNT_W-1:0]      message_count,
	output logic                  became_nonempty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

	function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// configuration
	logic [CNT_W-1:0]  max_msgs_q;
	logic [LEN_W-1:0]  max_size_q;
	logic [CNT_W-1:0]  cap_eff;
	logic [SIZE_W-1:0] size_eff;
	logic [SIZE_W-1:0] len_ext;

	// sequencer
	state_t           state_q, state_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] k_q, k_d;
	msg_t             item_q;
	logic             load_item;

	// message memory
	msg_t             mem [QUEUE_DEPTH];
	msg_t             rd_data_q;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	msg_t             wr_data;

	// result word
	logic                done_q, done_d;
	status_t             status_q, status_d;
	logic [HANDLE_W-1:0] handle_q, handle_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [PRIO_W-1:0]   prio_q, prio_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                nonempty_q, nonempty_d;

	assign cap_eff  = (int'(max_msgs_q) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : max_msgs_q;
	assign size_eff = (SIZE_W'(max_size_q) > SIZE_W'(MAX_LENGTH)) ? SIZE_W'(MAX_LENGTH)
		: SIZE_W'(max_size_q);
	assign len_ext  = SIZE_W'(length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msgs_q <= CNT_W'(RESET_MAX_MESSAGES);
			max_size_q <= LEN_W'(RESET_MAX_MESSAGE_SIZE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_MESSAGES:     max_msgs_q <= cfg_wdata[CNT_W-1:0];
				CFG_MAX_MESSAGE_SIZE: max_size_q <= cfg_wdata[LEN_W-1:0];
				default:              max_size_q <= max_size_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			head_q  <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			head_q  <= head_d;
			k_q     <= k_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			item_q.handle <= payload_handle;
			item_q.len    <= length;
			item_q.prio   <= priority_req[PRIO_W-1:0];
		end
		if (done_d) begin
			status_q   <= status_d;
			handle_q   <= handle_d;
			len_q      <= len_d;
			prio_q     <= prio_d;
			count_q    <= count_d;
			nonempty_q <= nonempty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d    = state_q;
		occ_d      = occ_q;
		head_d     = head_q;
		k_d        = k_q;
		load_item  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		wr_en      = 1'b0;
		wr_addr    = slot_addr(head_q, k_q);
		wr_data    = item_q;
		done_d     = 1'b0;
		status_d   = ST_OK;
		handle_d   = '0;
		len_d      = '0;
		prio_d     = '0;
		count_d    = occ_q;
		nonempty_d = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_SEND) begin
						priority if (priority_req[REQ_PRIO_W-1]) begin
							done_d   = 1'b1;
							status_d = ST_BAD_PRIO;
						end else if (len_ext > size_eff) begin
							done_d   = 1'b1;
							status_d = ST_TOO_LONG;
						end else if (occ_q >= cap_eff) begin
							done_d   = 1'b1;
							status_d = ST_FULL;
						end else begin
							load_item = 1'b1;
							k_d       = occ_q;
							state_d   = S_INS_RD;
						end
					end else begin
						priority if (len_ext < size_eff) begin
							done_d   = 1'b1;
							status_d = ST_BUF_SMALL;
						end else if (occ_q == '0) begin
							done_d   = 1'b1;
							status_d = ST_EMPTY;
						end else begin
							rd_en   = 1'b1;
							rd_addr = head_q;
							state_d = S_POP;
						end
					end
				end
			end
			S_INS_RD: begin
				if (k_q == '0) begin
					wr_en      = 1'b1;
					wr_data    = item_q;
					occ_d      = occ_q + CNT_W'(1);
					done_d     = 1'b1;
					count_d    = occ_q + CNT_W'(1);
					nonempty_d = (occ_q == '0);
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = slot_addr(head_q, k_q - CNT_W'(1));
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (rd_data_q.prio < item_q.prio) begin
					// lower priority message moves one slot toward the tail
					wr_en   = 1'b1;
					wr_data = rd_data_q;
					k_d     = k_q - CNT_W'(1);
					state_d = S_INS_RD;
				end else begin
					wr_en      = 1'b1;
					wr_data    = item_q;
					occ_d      = occ_q + CNT_W'(1);
					done_d     = 1'b1;
					count_d    = occ_q + CNT_W'(1);
					nonempty_d = (occ_q == '0);
					state_d    = S_IDLE;
				end
			end
			S_POP: begin
				done_d   = 1'b1;
				handle_d = rd_data_q.handle;
				len_d    = rd_data_q.len;
				prio_d   = rd_data_q.prio;
				head_d   = slot_addr(head_q, CNT_W'(1));
				occ_d    = occ_q - CNT_W'(1);
				count_d  = occ_q - CNT_W'(1);
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign out_handle      = handle_q;
	assign out_length      = len_q;
	assign out_priority    = prio_q;
	assign message_count   = count_q;
	assign became_nonempty = nonempty_q;

endmodule

/* rtl/pmq_checker.sv */
// ----------------------------------------------------------------------------
// pmq_checker
// port-level checks of the priority message queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pmq_checker
	import pmq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [HANDLE_W-1:0] out_handle,
	input logic [LEN_W-1:0]    out_length,
	input logic [PRIO_W-1:0]   out_priority,
	input logic [CNT_W-1:0]    message_count,
	input logic                became_nonempty
);

	// an accepted word is either being worked on or answered next cycle
	`ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

	// the first message in makes the count one
	`ASSERT_IMPLIES(a_nonempty_count, done && became_nonempty,
		status == ST_OK && message_count == CNT_W'(1))

	// rejected words carry no message
	`ASSERT_IMPLIES(a_reject_zero, done && status != ST_OK,
		out_handle == '0 && out_length == '0 && out_priority == '0 && !became_nonempty)

	// no result while idle without a word in flight
	`ASSERT_NEXT(a_no_spurious_done, !busy && !start, !done)

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.status          (status),
	.out_handle      (out_handle),
	.out_length      (out_length),
	.out_priority    (out_priority),
	.message_count   (message_count),
	.became_nonempty (became_nonempty)
);
